FILE: hdl/fsw_pkg.sv
// ----------------------------------------------------------------------------
// fsw_pkg: shared definitions for the sample window FIR filter
// Default sizes, the Q1.15 coefficient table and the control group that the
// sequencer hands to the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package fsw_pkg;

    // Default sizes of the filter.
    localparam int FSW_TAPS         = 51;
    localparam int FSW_SAMPLE_WIDTH = 16;
    localparam int FSW_COEF_WIDTH   = 16;

    // The nonzero part of the coefficient table is symmetric: half of it is stored.
    localparam int FSW_BASE_FRAC    = 15;
    localparam int FSW_HALF_TAPS    = 11;
    localparam int FSW_NONZERO_TAPS = 21;

    localparam logic signed [31:0] FSW_BASE_COEF [FSW_HALF_TAPS] = '{
        32'sd31, 32'sd108, 32'sd147, -32'sd48, -32'sd568, -32'sd1056,
        -32'sd677, 32'sd1297, 32'sd4632, 32'sd7886, 32'sd9246
    };

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic clr;     // clear the accumulator for a new request
        logic mul_en;  // form one product this cycle
    } t_mac_ctrl;

    // Coefficient of tap j, oldest sample first, scaled to cw bits with
    // cw-1 fraction bits. Narrower formats round half up.
    function automatic logic signed [31:0] fsw_coef(input int unsigned j,
                                                    input int unsigned cw);
        int unsigned      k;
        logic signed [31:0] c;
        k = 0;
        c = '0;
        if (j >= FSW_NONZERO_TAPS) begin
            return '0;
        end
        k = (j < FSW_HALF_TAPS) ? j : (FSW_NONZERO_TAPS - 1 - j);
        c = FSW_BASE_COEF[k];
        if (cw - 1 >= FSW_BASE_FRAC) begin
            return c <<< (cw - 1 - FSW_BASE_FRAC);
        end
        return (c + (32'sd1 <<< (FSW_BASE_FRAC - cw))) >>> (FSW_BASE_FRAC + 1 - cw);
    endfunction

endpackage

FILE: hdl/fsw_sample_if.sv
// ----------------------------------------------------------------------------
// fsw_sample_if: input channel of the sample window FIR filter
// Valid/ready handshake carrying one signed temperature sample per request.
// ----------------------------------------------------------------------------
interface fsw_sample_if #(
    parameter int WIDTH = 16
) ();
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

FILE: hdl/fsw_filtered_if.sv
// ----------------------------------------------------------------------------
// fsw_filtered_if: output channel of the sample window FIR filter
// Valid/ready handshake carrying one filtered temperature per request.
// ----------------------------------------------------------------------------
interface fsw_filtered_if #(
    parameter int WIDTH = 16
) ();
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface

FILE: hdl/fir_sample_window_filter_core.sv
// ----------------------------------------------------------------------------
// fir_sample_window_filter_core: FIR filter over a window of samples
// A chain of sample cells rotates past a single multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Each request carries one Q8.8 temperature sample. It is shifted into the
// tail of a chain of TAPS cells, dropping the oldest sample, and the chain
// then rotates once all the way round, presenting the samples oldest first
// to one multiply-accumulate unit that applies the Q1.(COEF_WIDTH-1)
// coefficients. The sum is rounded half up and saturated to the sample
// width. One request occupies the block while the single multiplier visits
// each cell in turn; the next sample is taken as soon as the result is in
// the output register, even if that result has not yet been collected.
// ----------------------------------------------------------------------------
module fir_sample_window_filter_core
    import fsw_pkg::*;
#(
    parameter int TAPS         = FSW_TAPS,
    parameter int SAMPLE_WIDTH = FSW_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = FSW_COEF_WIDTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    fsw_sample_if.sink     i_sample_ch,
    fsw_filtered_if.source o_filtered_ch
);

    localparam int CNT_W = $clog2(TAPS);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MAC   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                     r_state;
    logic [1:0]                     n_state;
    logic [CNT_W-1:0]               r_cnt;
    logic [CNT_W-1:0]               n_cnt;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_data;

    logic                           w_accept;
    logic                           w_shift;
    logic                           w_out_free;
    logic signed [SAMPLE_WIDTH-1:0] w_cell [TAPS];
    logic signed [SAMPLE_WIDTH-1:0] w_tail_in;
    logic signed [COEF_WIDTH-1:0]   w_coef;
    logic signed [SAMPLE_WIDTH-1:0] w_result;
    t_mac_ctrl                      w_mac_ctrl;

    // Handshake: a new sample is taken only between requests.
    assign i_sample_ch.ready = (r_state == S_IDLE);
    assign w_accept          = i_sample_ch.valid && i_sample_ch.ready;
    assign w_out_free        = !r_out_valid || o_filtered_ch.ready;

    // The chain moves on acceptance (shift in) and while rotating.
    assign w_shift   = w_accept || (r_state == S_MAC);
    assign w_tail_in = (r_state == S_IDLE) ? i_sample_ch.sample : w_cell[0];

    // Chain of sample cells; cell 0 holds the oldest sample.
    for (genvar g = 0; g < TAPS; g++) begin : g_cell
        fsw_cell #(
            .SAMPLE_WIDTH(SAMPLE_WIDTH)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_shift(w_shift),
            .i_data ((g == TAPS - 1) ? w_tail_in : w_cell[(g + 1) % TAPS]),
            .o_data (w_cell[g])
        );
    end

    // Sequencer: one rotation step per tap, then drain and finish.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_MAC;
                    n_cnt   = '0;
                end
            end
            S_MAC: begin
                if (r_cnt == CNT_W'(TAPS - 1)) begin
                    n_state = S_DRAIN;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Coefficient for the tap now at the head of the chain.
    assign w_coef = COEF_WIDTH'(fsw_coef(32'(r_cnt), COEF_WIDTH));

    assign w_mac_ctrl.clr    = w_accept;
    assign w_mac_ctrl.mul_en = (r_state == S_MAC);

    fsw_mac #(
        .TAPS        (TAPS),
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_mac_ctrl),
        .i_sample(w_cell[0]),
        .i_coef  (w_coef),
        .o_result(w_result)
    );

    // Output register: holds the result until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_filtered_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_data <= w_result;
        end
    end

    assign o_filtered_ch.valid    = r_out_valid;
    assign o_filtered_ch.filtered = r_out_data;

    // The tap counter only runs during the rotation.
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_MAC) |-> (r_cnt == '0))
        else $error("tap counter moved outside the rotation");

    // An accepted sample always starts a rotation.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_MAC))
        else $error("accepted sample did not start a rotation");

    // Finishing a request always leaves a result in the output register.
    a_done_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && n_state == S_IDLE) |=> r_out_valid)
        else $error("finished request produced no result");

    // No new sample is taken while the rotation is in progress.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC || r_state == S_DRAIN) |-> !w_accept)
        else $error("sample accepted during a rotation");

endmodule

FILE: hdl/fsw_cell.sv
// ----------------------------------------------------------------------------
// fsw_cell: one sample slot of the window chain
// Holds one sample and loads the sample on its input whenever the chain moves.
// ----------------------------------------------------------------------------
module fsw_cell
    import fsw_pkg::*;
#(
    parameter int SAMPLE_WIDTH = FSW_SAMPLE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_shift,
    input  logic signed [SAMPLE_WIDTH-1:0] i_data,
    output logic signed [SAMPLE_WIDTH-1:0] o_data
);

    logic signed [SAMPLE_WIDTH-1:0] r_data;

    // The window starts empty, so every slot resets to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule

FILE: hdl/fsw_mac.sv
// ----------------------------------------------------------------------------
// fsw_mac: multiply-accumulate unit with rounding and saturation
// One registered product per cycle while mul_en is set, into an exact
// accumulator; the rounded, saturated sum is offered combinationally.
// ----------------------------------------------------------------------------
module fsw_mac
    import fsw_pkg::*;
#(
    parameter int TAPS         = FSW_TAPS,
    parameter int SAMPLE_WIDTH = FSW_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = FSW_COEF_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_mac_ctrl                      i_ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic signed [COEF_WIDTH-1:0]   i_coef,
    output logic signed [SAMPLE_WIDTH-1:0] o_result
);

    localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W  = PROD_W + $clog2(TAPS);

    localparam logic signed [ACC_W-1:0] HALF_LSB =
        ACC_W'(1) <<< (COEF_WIDTH - 2);
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_v;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_round;

    // Product stage: one sample times one coefficient per cycle while mul_en is set.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
        end else begin
            r_prod_v <= i_ctrl.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= i_sample * i_coef;
        end
    end

    // Accumulator: cleared when a new request starts, then sums the products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctrl.clr) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Round half up to the sample format and clamp to its limits.
    assign w_round = (r_acc + HALF_LSB) >>> (COEF_WIDTH - 1);

    always_comb begin
        if (w_round > SAT_HI) begin
            o_result = SAT_HI[SAMPLE_WIDTH-1:0];
        end else if (w_round < SAT_LO) begin
            o_result = SAT_LO[SAMPLE_WIDTH-1:0];
        end else begin
            o_result = w_round[SAMPLE_WIDTH-1:0];
        end
    end

endmodule

FILE: verif/fir_sample_window_filter_checker.sv
// ----------------------------------------------------------------------------
// fir_sample_window_filter_checker: scoreboard for the sample window filter
// Watches both channels. Each accepted sample is run through a window model
// of the filter, and each collected result is compared with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module fir_sample_window_filter_checker
    import fsw_pkg::*;
#(
    parameter int TAPS         = FSW_TAPS,
    parameter int SAMPLE_WIDTH = FSW_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = FSW_COEF_WIDTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    fsw_sample_if   i_sample_ch,
    fsw_filtered_if i_filtered_ch,
    output int      o_fail_count,
    output int      o_outstanding
);

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;

    // Model state: the window of past samples and the slot for the next one.
    t_sample     window [TAPS];
    int unsigned wr_ptr;

    // Predicted filter outputs, oldest first.
    t_sample expected_filtered [$];
    t_sample oldest_expected;
    int      fail_count  = 0;
    int      outstanding = 0;

    assign o_fail_count  = fail_count;
    assign o_outstanding = outstanding;

    // Weight of tap j, counted from the oldest sample. Only the first taps
    // carry a weight, and these are symmetric about the middle one of them.
    // Narrower coefficient formats round half up.
    function automatic longint tap_weight(input int unsigned j);
        int unsigned k;
        longint      c;
        k = 0;
        c = 0;
        if (j >= FSW_NONZERO_TAPS) begin
            return 0;
        end
        k = (j < FSW_HALF_TAPS) ? j : (FSW_NONZERO_TAPS - 1 - j);
        c = longint'(FSW_BASE_COEF[k]);
        if (COEF_WIDTH - 1 >= FSW_BASE_FRAC) begin
            return c <<< (COEF_WIDTH - 1 - FSW_BASE_FRAC);
        end
        return (c + (longint'(1) <<< (FSW_BASE_FRAC - COEF_WIDTH)))
               >>> (FSW_BASE_FRAC + 1 - COEF_WIDTH);
    endfunction

    // Store the new sample, then form the rounded and saturated weighted sum
    // of the whole window, oldest sample first.
    function automatic t_sample filter_next_sample(input t_sample s);
        longint      acc;
        longint      rounded;
        longint      hi;
        longint      lo;
        int unsigned idx;
        acc = 0;
        window[wr_ptr] = s;
        wr_ptr = (wr_ptr == TAPS - 1) ? 0 : wr_ptr + 1;
        idx = wr_ptr;
        for (int unsigned j = 0; j < TAPS; j++) begin
            acc += longint'(window[idx]) * tap_weight(j);
            idx = (idx == TAPS - 1) ? 0 : idx + 1;
        end
        rounded = (acc + (longint'(1) <<< (COEF_WIDTH - 2))) >>> (COEF_WIDTH - 1);
        hi = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (rounded > hi) begin
            rounded = hi;
        end
        if (rounded < lo) begin
            rounded = lo;
        end
        return t_sample'(rounded);
    endfunction

    // Collect results first, then record the prediction for a new request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (window[i]) window[i] = '0;
            wr_ptr = 0;
            expected_filtered.delete();
            outstanding = 0;
        end else begin
            if (i_filtered_ch.valid && i_filtered_ch.ready) begin
                if (expected_filtered.size() == 0) begin
                    $error("filtered: no result expected, actual %0d",
                           i_filtered_ch.filtered);
                    fail_count++;
                end else begin
                    oldest_expected = expected_filtered.pop_front();
                    if (i_filtered_ch.filtered !== oldest_expected) begin
                        $error("filtered: expected %0d, actual %0d",
                               oldest_expected, i_filtered_ch.filtered);
                        fail_count++;
                    end
                end
            end
            if (i_sample_ch.valid && i_sample_ch.ready) begin
                expected_filtered.push_back(filter_next_sample(i_sample_ch.sample));
            end
            outstanding = expected_filtered.size();
        end
    end

endmodule

FILE: verif/fir_sample_window_filter_core_tb.sv
// ----------------------------------------------------------------------------
// fir_sample_window_filter_core_tb: test bench for the sample window filter
// Drives samples with random gaps and collects results with random stalls,
// including one long hold-off that backs the filter up. A checker beside
// the block predicts every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module fir_sample_window_filter_core_tb;
    import fsw_pkg::*;

    localparam int TAPS  = FSW_TAPS;
    localparam int SW    = FSW_SAMPLE_WIDTH;
    localparam int CW    = FSW_COEF_WIDTH;
    localparam int HOLD  = 400;

    logic i_clk;
    logic i_rst_n;

    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int fail_count;
    int outstanding;

    fsw_sample_if   #(.WIDTH(SW)) smp_ch ();
    fsw_filtered_if #(.WIDTH(SW)) filt_ch ();

    fir_sample_window_filter_core #(
        .TAPS        (TAPS),
        .SAMPLE_WIDTH(SW),
        .COEF_WIDTH  (CW)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample_ch  (smp_ch.sink),
        .o_filtered_ch(filt_ch.source)
    );

    fir_sample_window_filter_checker #(
        .TAPS        (TAPS),
        .SAMPLE_WIDTH(SW),
        .COEF_WIDTH  (CW)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample_ch  (smp_ch),
        .i_filtered_ch(filt_ch),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Overall time limit.
    initial begin
        #(4 * 400_000);
        $display("fir_sample_window_filter_core_tb failed");
        $finish;
    end

    // Result side: random stalls, or a long counted hold-off when asked.
    initial begin
        filt_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left != 0) begin
                filt_ch.ready <= 1'b0;
                hold_left = hold_left - 1;
            end else if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left = HOLD - 1;
                filt_ch.ready <= 1'b0;
            end else begin
                filt_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Offer one sample after a random gap and wait for the request to go.
    task automatic send_sample(input logic [SW-1:0] value);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            smp_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp_ch.valid  <= 1'b1;
        smp_ch.sample <= value;
        @(posedge i_clk);
        while (!smp_ch.ready) @(posedge i_clk);
    endtask

    // A full window whose oldest samples take the extreme value of the sign
    // of their weight, which drives the sum past the output range.
    task automatic send_saturating_window(input bit negative);
        int unsigned k;
        bit          up;
        for (int unsigned j = 0; j < TAPS; j++) begin
            if (j < FSW_NONZERO_TAPS) begin
                k = (j < FSW_HALF_TAPS) ? j : (FSW_NONZERO_TAPS - 1 - j);
                up = (FSW_BASE_COEF[k] > 0) ^ negative;
                send_sample(up ? 16'h7fff : 16'h8000);
            end else begin
                send_sample(SW'($urandom));
            end
        end
    endtask

    // One idling phase: a saturating window, then runs of mixed content.
    task automatic run_random_phase(input int tx_pct, input int rx_pct,
                                    input int n_items, input bit negative);
        int            sent;
        int            kind;
        int            run_len;
        logic [SW-1:0] value;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        send_saturating_window(negative);
        sent = TAPS;
        while (sent < n_items) begin
            kind = $urandom_range(9);
            run_len = $urandom_range(20, 5);
            value = SW'($urandom);
            if (kind == 0) begin
                send_saturating_window($urandom_range(1));
                sent += TAPS;
            end else begin
                for (int i = 0; i < run_len; i++) begin
                    if (kind <= 5 && kind > 2) begin
                        // Plausible temperatures, about -10 to +40 degrees.
                        value = SW'(int'($urandom_range(12800)) - 2560);
                    end else if (kind > 5) begin
                        value = SW'($urandom);
                    end
                    send_sample(value);
                end
                sent += run_len;
            end
        end
    endtask

    // Stimulus and verdict.
    initial begin
        smp_ch.valid  <= 1'b0;
        smp_ch.sample <= '0;
        i_rst_n       <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, small steps and alternating bit patterns.
        send_sample(16'h0000);
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'hffff);
        send_sample(16'h0001);
        send_sample(16'h0100);
        send_sample(16'hff00);
        send_sample(16'h5555);
        send_sample(16'haaaa);
        send_sample(16'h00ff);
        send_sample(16'h7fff);
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'h8000);

        // Long hold-off on the result side while samples keep coming.
        hold_requests = hold_requests + 1;
        for (int i = 0; i < 8; i++) begin
            send_sample(SW'($urandom));
        end

        run_random_phase(0, 0, 90, 1'b0);
        run_random_phase(54, 0, 90, 1'b1);
        run_random_phase(0, 54, 90, 1'b0);
        run_random_phase(34, 34, 90, 1'b1);
        smp_ch.valid <= 1'b0;

        // Drain, then allow for any late stray result.
        while (outstanding != 0) @(posedge i_clk);
        repeat (2 * (TAPS + 3)) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("fir_sample_window_filter_core_tb passed");
        end else begin
            $display("fir_sample_window_filter_core_tb failed");
        end
        $finish;
    end

endmodule

FILE: fir_sample_window_filter_core.f
hdl/fsw_pkg.sv
hdl/fsw_sample_if.sv
hdl/fsw_filtered_if.sv
hdl/fsw_cell.sv
hdl/fsw_mac.sv
hdl/fir_sample_window_filter_core.sv
verif/fir_sample_window_filter_checker.sv
verif/fir_sample_window_filter_core_tb.sv
